// ===== src/ll1p_pkg.sv =====
// ll1p_pkg: shared constants, types and the rule decoder of the postfix parser
// no dependencies; imported by the interfaces and every module of the block
package ll1p_pkg;

	localparam int RULE_STACK_DEPTH = 32;
	localparam int KIND_W = 3;
	localparam int VALUE_W = 64;
	localparam int OP_W = 2;
	localparam int ERR_W = 2;
	localparam int RULE_W = 5;
	localparam int CNT_W = $clog2(RULE_STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(RULE_STACK_DEPTH);

	// token kinds
	localparam logic [KIND_W-1:0] K_NUM = 3'd0;
	localparam logic [KIND_W-1:0] K_ADD = 3'd1;
	localparam logic [KIND_W-1:0] K_MUL = 3'd2;
	localparam logic [KIND_W-1:0] K_LP = 3'd3;
	localparam logic [KIND_W-1:0] K_RP = 3'd4;

	// result kinds
	localparam logic [KIND_W-1:0] O_NUM = 3'd0;
	localparam logic [KIND_W-1:0] O_UN = 3'd1;
	localparam logic [KIND_W-1:0] O_BIN = 3'd2;
	localparam logic [KIND_W-1:0] O_DONE = 3'd3;
	localparam logic [KIND_W-1:0] O_ERR = 3'd4;

	// operators
	localparam logic [OP_W-1:0] OP_PLUS = 2'd0;
	localparam logic [OP_W-1:0] OP_MUL = 2'd2;

	// error codes
	localparam logic [ERR_W-1:0] E_NONE = 2'd0;
	localparam logic [ERR_W-1:0] E_SYNTAX = 2'd1;
	localparam logic [ERR_W-1:0] E_OVERFLOW = 2'd2;

	// rule codes
	localparam logic [RULE_W-1:0] R_E = 5'd0;
	localparam logic [RULE_W-1:0] R_E2 = 5'd1;
	localparam logic [RULE_W-1:0] R_T = 5'd2;
	localparam logic [RULE_W-1:0] R_T2 = 5'd3;
	localparam logic [RULE_W-1:0] R_F = 5'd4;
	localparam logic [RULE_W-1:0] R_RP = 5'd5;
	localparam logic [RULE_W-1:0] R_UN_P = 5'd6;
	localparam logic [RULE_W-1:0] R_UN_M = 5'd7;
	localparam logic [RULE_W-1:0] R_BIN_P = 5'd8;
	localparam logic [RULE_W-1:0] R_BIN_M = 5'd9;
	localparam logic [RULE_W-1:0] R_BIN_X = 5'd10;
	localparam logic [RULE_W-1:0] R_BIN_D = 5'd11;

	typedef enum logic [3:0] {
		S_INIT,
		S_FETCH,
		S_POP,
		S_DISP,
		S_PUSH,
		S_NEXT,
		S_FIN,
		S_DONE,
		S_ERR
	} step_t;

	typedef enum logic [2:0] {
		C_NEXT,
		C_JUMP,
		C_WAIT_IN,
		C_EMPTY,
		C_ERR,
		C_PUSH_MORE,
		C_NOT_CONSUMED
	} cond_t;

	typedef struct packed {
		logic accept;
		logic pop;
		logic disp;
		logic push;
		logic fin;
		logic restart;
		logic done_emit;
		logic err_emit;
		cond_t cond;
		step_t target;
	} ctl_t;

	typedef struct packed {
		logic in_valid;
		logic empty;
		logic err_now;
		logic push_more;
		logic consumed;
		logic out_blocked;
	} stat_t;

	typedef struct packed {
		logic [1:0] push_cnt;
		logic [2:0][RULE_W-1:0] code;
		logic consumed;
		logic syntax;
		logic emit;
		logic [KIND_W-1:0] kind;
		logic [OP_W-1:0] op;
	} act_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OP_W-1:0] op;
		logic [VALUE_W-1:0] value;
		logic [ERR_W-1:0] err;
	} res_t;

	// one popped rule against the lookahead token; code[0] is pushed first
	function automatic act_t rule_decode(logic [RULE_W-1:0] rule, logic [KIND_W-1:0] kind,
			logic sel);
		act_t a;
		a = '0;
		unique case (rule) inside
			R_E: begin
				a.push_cnt = 2'd2;
				a.code[0] = R_E2;
				a.code[1] = R_T;
			end
			R_E2: begin
				if (kind == K_ADD) begin
					a.push_cnt = 2'd3;
					a.code[0] = R_E2;
					a.code[1] = R_BIN_P + RULE_W'(sel);
					a.code[2] = R_T;
					a.consumed = 1'b1;
				end
			end
			R_T: begin
				a.push_cnt = 2'd2;
				a.code[0] = R_T2;
				a.code[1] = R_F;
			end
			R_T2: begin
				if (kind == K_MUL) begin
					a.push_cnt = 2'd3;
					a.code[0] = R_T2;
					a.code[1] = R_BIN_X + RULE_W'(sel);
					a.code[2] = R_F;
					a.consumed = 1'b1;
				end
			end
			R_F: begin
				if (kind == K_NUM) begin
					a.emit = 1'b1;
					a.kind = O_NUM;
					a.consumed = 1'b1;
				end else if (kind == K_ADD) begin
					a.push_cnt = 2'd2;
					a.code[0] = R_UN_P + RULE_W'(sel);
					a.code[1] = R_F;
					a.consumed = 1'b1;
				end else if (kind == K_LP) begin
					a.push_cnt = 2'd2;
					a.code[0] = R_RP;
					a.code[1] = R_E;
					a.consumed = 1'b1;
				end else begin
					a.syntax = 1'b1;
				end
			end
			R_RP: begin
				if (kind == K_RP) begin
					a.consumed = 1'b1;
				end else begin
					a.syntax = 1'b1;
				end
			end
			R_UN_P, R_UN_M: begin
				a.emit = 1'b1;
				a.kind = O_UN;
				a.op = OP_PLUS + OP_W'(rule[0]);
			end
			R_BIN_P, R_BIN_M, R_BIN_X, R_BIN_D: begin
				a.emit = 1'b1;
				a.kind = O_BIN;
				a.op = rule[OP_W-1:0];
			end
			default: begin
				a.syntax = 1'b1;
			end
		endcase
		return a;
	endfunction

endpackage

// ===== src/ll1p_tok_if.sv =====
// ll1p_tok_if: token channel, one lexed token per beat
// depends on ll1p_pkg for field widths
interface ll1p_tok_if import ll1p_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] token_kind;
	logic op_select;
	logic [VALUE_W-1:0] number_value;

	modport source(output valid, output token_kind, output op_select, output number_value,
		input ready);
	modport sink(input valid, input token_kind, input op_select, input number_value,
		output ready);
endinterface

// ===== src/ll1p_res_if.sv =====
// ll1p_res_if: result channel, one postfix item, completion or error per beat
// depends on ll1p_pkg for field widths
interface ll1p_res_if import ll1p_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] out_kind;
	logic [OP_W-1:0] out_op;
	logic [VALUE_W-1:0] out_value;
	logic [ERR_W-1:0] error_code;
	logic last_of_run;

	modport source(output valid, output out_kind, output out_op, output out_value,
		output error_code, output last_of_run, input ready);
	modport sink(input valid, input out_kind, input out_op, input out_value,
		input error_code, input last_of_run, output ready);
endinterface

// ===== src/ll1_expression_to_postfix.sv =====
// ll1_expression_to_postfix: top level of the predictive expression parser
// depends on ll1p_pkg, ll1p_tok_if, ll1p_res_if, ll1p_useq and ll1p_dpath

// Takes lexed arithmetic tokens one beat at a time and emits the expression in
// postfix order: numbers, unary and binary operators, then a completion beat when
// the expression ends (the ending token is dropped) or an error beat on a syntax
// error or rule stack overflow (the token is dropped); the parser then restarts.
// The last result beat caused by a token carries last_of_run. Tokens are handled
// one at a time by a small control program over a single-port rule stack memory:
// it fetches a token, then pops a rule, dispatches it and pushes its new rules
// one at a time, and repeats until the token is consumed. When the expression
// completes, the pop finds the stack empty and the completion beat follows; a
// rule that fails ends the token with its error beat instead. After reset the start
// rule is loaded before the first token is taken. Output beats are staged
// through a hold register and an output register, so the parser keeps working while
// the last result waits to be taken; a step that may emit waits while both are full.
module ll1_expression_to_postfix import ll1p_pkg::*; (
	input logic clk,
	input logic arst_n,
	ll1p_tok_if.sink tok,
	ll1p_res_if.source res
);

	ctl_t ctl;
	stat_t st;

	ll1p_useq u_useq (
		.clk(clk),
		.arst_n(arst_n),
		.st(st),
		.ctl(ctl)
	);

	ll1p_dpath u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.st(st),
		.tok(tok),
		.res(res)
	);

endmodule

// ===== src/ll1p_useq.sv =====
// ll1p_useq: step counter and control store of the parser program
// depends on ll1p_pkg for step, condition and control word types
module ll1p_useq import ll1p_pkg::*; (
	input logic clk,
	input logic arst_n,
	input stat_t st,
	output ctl_t ctl
);

	step_t step_q;
	step_t step_d;
	ctl_t word;
	logic taken;
	logic stall;

	function automatic ctl_t rom(step_t s);
		ctl_t w;
		w = '0;
		w.cond = C_NEXT;
		w.target = S_FETCH;
		unique case (s)
			S_INIT: begin
				w.restart = 1'b1;
			end
			S_FETCH: begin
				w.accept = 1'b1;
				w.cond = C_WAIT_IN;
				w.target = S_FETCH;
			end
			S_POP: begin
				w.pop = 1'b1;
				w.cond = C_EMPTY;
				w.target = S_DONE;
			end
			S_DISP: begin
				w.disp = 1'b1;
				w.cond = C_ERR;
				w.target = S_ERR;
			end
			S_PUSH: begin
				w.push = 1'b1;
				w.cond = C_PUSH_MORE;
				w.target = S_PUSH;
			end
			S_NEXT: begin
				w.cond = C_NOT_CONSUMED;
				w.target = S_POP;
			end
			S_FIN: begin
				w.fin = 1'b1;
				w.cond = C_JUMP;
				w.target = S_FETCH;
			end
			S_DONE: begin
				w.done_emit = 1'b1;
				w.restart = 1'b1;
				w.cond = C_JUMP;
				w.target = S_FIN;
			end
			S_ERR: begin
				w.err_emit = 1'b1;
				w.restart = 1'b1;
				w.cond = C_JUMP;
				w.target = S_FIN;
			end
			default: begin
				w.cond = C_JUMP;
				w.target = S_INIT;
			end
		endcase
		return w;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_INIT;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		word = rom(step_q);
		stall = (word.disp || word.fin || word.done_emit || word.err_emit) && st.out_blocked;
		unique case (word.cond)
			C_NEXT: taken = 1'b0;
			C_JUMP: taken = 1'b1;
			C_WAIT_IN: taken = !st.in_valid;
			C_EMPTY: taken = st.empty;
			C_ERR: taken = st.err_now;
			C_PUSH_MORE: taken = st.push_more;
			C_NOT_CONSUMED: taken = !st.consumed;
			default: taken = 1'b0;
		endcase
		if (stall) begin
			step_d = step_q;
			ctl = '0;
		end else begin
			step_d = taken ? word.target : step_t'(4'(step_q) + 4'd1);
			ctl = word;
		end
	end

endmodule

// ===== src/ll1p_dpath.sv =====
// ll1p_dpath: rule stack memory, token and action registers, result hold and output stage
// depends on ll1p_pkg, ll1p_tok_if and ll1p_res_if
module ll1p_dpath import ll1p_pkg::*; (
	input logic clk,
	input logic arst_n,
	input ctl_t ctl,
	output stat_t st,
	ll1p_tok_if.sink tok,
	ll1p_res_if.source res
);

	localparam logic [CNT_W:0] DEPTH_LIM = (CNT_W + 1)'(RULE_STACK_DEPTH);

	logic [RULE_W-1:0] stack_mem [RULE_STACK_DEPTH];
	logic [RULE_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pop_addr;
	logic [KIND_W-1:0] kind_q;
	logic sel_q;
	logic [VALUE_W-1:0] value_q;
	act_t act_d;
	act_t act_q;
	logic consumed_q;
	logic [ERR_W-1:0] err_q;
	logic [1:0] push_idx_q;
	logic [1:0] remaining;
	logic overflow;
	logic pop_en;
	logic push_en;
	logic mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [RULE_W-1:0] mem_wd;
	logic new_valid;
	res_t new_res;
	logic hold_valid_q;
	res_t hold_q;
	logic move;
	logic move_last;
	logic out_valid_q;
	res_t out_q;
	logic out_last_q;

	assign tok.ready = ctl.accept;

	assign pop_addr = count_q - CNT_W'(1);
	assign act_d = rule_decode(rd_q, kind_q, sel_q);
	assign overflow = ((CNT_W + 1)'(count_q) + (CNT_W + 1)'(act_d.push_cnt)) > DEPTH_LIM;
	assign remaining = act_q.push_cnt - push_idx_q;
	assign pop_en = ctl.pop && (count_q != '0);
	assign push_en = ctl.push && (remaining != 2'd0);

	assign mem_we = ctl.restart || push_en;
	assign mem_wa = ctl.restart ? '0 : count_q[ADDR_W-1:0];
	assign mem_wd = ctl.restart ? R_E : act_q.code[push_idx_q];

	always_comb begin
		st.in_valid = tok.valid;
		st.empty = (count_q == '0);
		st.err_now = act_d.syntax || overflow;
		st.push_more = (remaining > 2'd1);
		st.consumed = consumed_q;
		st.out_blocked = out_valid_q && !res.ready && hold_valid_q;
	end

	// stack memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		if (pop_en) begin
			rd_q <= stack_mem[pop_addr[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(1);
		end else if (ctl.restart) begin
			count_q <= CNT_W'(1);
		end else if (pop_en) begin
			count_q <= pop_addr;
		end else if (push_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// token and action registers
	always_ff @(posedge clk) begin
		if (ctl.accept && tok.valid) begin
			kind_q <= tok.token_kind;
			sel_q <= tok.op_select;
			value_q <= tok.number_value;
		end
		if (ctl.disp) begin
			act_q <= act_d;
			err_q <= act_d.syntax ? E_SYNTAX : E_OVERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			consumed_q <= 1'b0;
			push_idx_q <= 2'd0;
		end else begin
			if (ctl.disp) begin
				consumed_q <= act_d.consumed;
				push_idx_q <= 2'd0;
			end else if (push_en) begin
				push_idx_q <= push_idx_q + 2'd1;
			end
		end
	end

	// new result from the current step
	always_comb begin
		new_res = '0;
		new_valid = 1'b0;
		if (ctl.disp && act_d.emit && !st.err_now) begin
			new_valid = 1'b1;
			new_res.kind = act_d.kind;
			new_res.op = act_d.op;
			new_res.value = (act_d.kind == O_NUM) ? value_q : '0;
			new_res.err = E_NONE;
		end else if (ctl.done_emit) begin
			new_valid = 1'b1;
			new_res.kind = O_DONE;
		end else if (ctl.err_emit) begin
			new_valid = 1'b1;
			new_res.kind = O_ERR;
			new_res.err = err_q;
		end
	end

	// hold keeps one result back until it is known whether it ends the run
	assign move = hold_valid_q && (new_valid || ctl.fin);
	assign move_last = ctl.fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (new_valid) begin
				hold_valid_q <= 1'b1;
			end else if (ctl.fin) begin
				hold_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (new_valid) begin
			hold_q <= new_res;
		end
		if (move) begin
			out_q <= hold_q;
			out_last_q <= move_last;
		end
	end

	assign res.valid = out_valid_q;
	assign res.out_kind = out_q.kind;
	assign res.out_op = out_q.op;
	assign res.out_value = out_q.value;
	assign res.error_code = out_q.err;
	assign res.last_of_run = out_last_q;

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench of ll1_expression_to_postfix, tokens in and postfix beats out
// a local parser model predicts every result beat; uses ll1p_pkg, ll1p_tok_if, ll1p_res_if
`timescale 1ns / 1ps

module tb_top import ll1p_pkg::*; ();

	localparam logic [KIND_W-1:0] K_END = 3'd5;
	localparam logic [KIND_W-1:0] K_ODD6 = 3'd6;
	localparam logic [KIND_W-1:0] K_ODD7 = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam int unsigned DRAIN_CYCLES = 250;
	localparam int unsigned RANDOM_ITEMS = 410;
	localparam int unsigned REPORT_MAX = 10;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OP_W-1:0] op;
		logic [VALUE_W-1:0] value;
		logic [ERR_W-1:0] err;
		logic last;
	} postfix_beat_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic sel;
		logic [VALUE_W-1:0] value;
	} token_t;

	logic clk = 1'b0;
	logic arst_n;

	ll1p_tok_if tok();
	ll1p_res_if res();

	ll1_expression_to_postfix u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.tok(tok),
		.res(res)
	);

	logic [RULE_W-1:0] rule_mem [RULE_STACK_DEPTH];
	int unsigned rule_cnt;
	postfix_beat_t postfix_expected[$];
	token_t expr_tokens[$];
	int unsigned mismatch_cnt = 0;
	int unsigned cycle_cnt = 0;
	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	bit hold_active = 1'b0;
	int unsigned hold_len;
	event hold_go;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// parser model
	function automatic void parser_restart();
		rule_mem[0] = R_E;
		rule_cnt = 1;
	endfunction

	function automatic bit rule_push(int unsigned n, logic [RULE_W-1:0] c0,
			logic [RULE_W-1:0] c1, logic [RULE_W-1:0] c2);
		logic [RULE_W-1:0] codes [3];
		codes[0] = c0;
		codes[1] = c1;
		codes[2] = c2;
		if (rule_cnt + n > RULE_STACK_DEPTH)
			return 1'b0;
		for (int i = 0; i < n; i++) begin
			rule_mem[rule_cnt] = codes[i];
			rule_cnt++;
		end
		return 1'b1;
	endfunction

	function automatic postfix_beat_t make_beat(logic [KIND_W-1:0] kind, logic [OP_W-1:0] op,
			logic [VALUE_W-1:0] value, logic [ERR_W-1:0] err);
		postfix_beat_t b;
		b.kind = kind;
		b.op = op;
		b.value = value;
		b.err = err;
		b.last = 1'b0;
		return b;
	endfunction

	function automatic void predict_postfix(logic [KIND_W-1:0] kind, logic sel,
			logic [VALUE_W-1:0] value);
		postfix_beat_t beats[$];
		logic [RULE_W-1:0] rule;
		logic [ERR_W-1:0] err;
		bit consumed;
		bit ended;
		bit ok;
		err = E_NONE;
		consumed = 1'b0;
		ended = 1'b0;
		if (rule_cnt == 0 || rule_cnt > RULE_STACK_DEPTH)
			parser_restart();
		while (!consumed && !ended && err == E_NONE) begin
			ok = 1'b1;
			if (rule_cnt == 0) begin
				// expression complete, lookahead token dropped
				beats.push_back(make_beat(O_DONE, OP_PLUS, '0, E_NONE));
				parser_restart();
				ended = 1'b1;
			end else begin
				rule_cnt--;
				rule = rule_mem[rule_cnt];
				case (rule)
					R_E: begin
						ok = rule_push(2, R_E2, R_T, R_E);
					end
					R_E2: begin
						if (kind == K_ADD) begin
							ok = rule_push(3, R_E2, R_BIN_P + RULE_W'(sel), R_T);
							consumed = 1'b1;
						end
					end
					R_T: begin
						ok = rule_push(2, R_T2, R_F, R_E);
					end
					R_T2: begin
						if (kind == K_MUL) begin
							ok = rule_push(3, R_T2, R_BIN_X + RULE_W'(sel), R_F);
							consumed = 1'b1;
						end
					end
					R_F: begin
						if (kind == K_NUM) begin
							beats.push_back(make_beat(O_NUM, OP_PLUS, value, E_NONE));
							consumed = 1'b1;
						end else if (kind == K_ADD) begin
							ok = rule_push(2, R_UN_P + RULE_W'(sel), R_F, R_E);
							consumed = 1'b1;
						end else if (kind == K_LP) begin
							ok = rule_push(2, R_RP, R_E, R_E);
							consumed = 1'b1;
						end else begin
							err = E_SYNTAX;
						end
					end
					R_RP: begin
						if (kind == K_RP)
							consumed = 1'b1;
						else
							err = E_SYNTAX;
					end
					R_UN_P, R_UN_M: begin
						beats.push_back(make_beat(O_UN, OP_W'(rule - R_UN_P), '0, E_NONE));
					end
					R_BIN_P, R_BIN_M, R_BIN_X, R_BIN_D: begin
						beats.push_back(make_beat(O_BIN, OP_W'(rule - R_BIN_P), '0, E_NONE));
					end
					default: begin
						err = E_SYNTAX;
					end
				endcase
				if (!ok)
					err = E_OVERFLOW;
			end
		end
		if (err != E_NONE) begin
			beats.push_back(make_beat(O_ERR, OP_PLUS, '0, err));
			parser_restart();
		end
		if (beats.size() > 0)
			beats[beats.size() - 1].last = 1'b1;
		foreach (beats[i])
			postfix_expected.push_back(beats[i]);
	endfunction

	// result side
	task automatic report_mismatch(string what, postfix_beat_t want, postfix_beat_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= REPORT_MAX)
			$display("mismatch, %s: expected kind=%0d op=%0d value=%h err=%0d last=%0d, got kind=%0d op=%0d value=%h err=%0d last=%0d",
				what, want.kind, want.op, want.value, want.err, want.last,
				got.kind, got.op, got.value, got.err, got.last);
	endtask

	always @(posedge clk) begin
		postfix_beat_t got;
		postfix_beat_t want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			got = {res.out_kind, res.out_op, res.out_value, res.error_code, res.last_of_run};
			if (postfix_expected.size() == 0) begin
				report_mismatch("beat with none expected", '0, got);
			end else begin
				want = postfix_expected.pop_front();
				if (got !== want)
					report_mismatch("wrong field", want, got);
			end
		end
	end

	initial begin
		int unsigned stall_left;
		stall_left = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_active) begin
				res.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off
	initial begin
		forever begin
			@(hold_go);
			hold_active <= 1'b1;
			repeat (hold_len) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	// token side
	task automatic send_token(logic [KIND_W-1:0] kind, logic sel, logic [VALUE_W-1:0] value);
		int unsigned gap;
		tok.valid <= 1'b1;
		tok.token_kind <= kind;
		tok.op_select <= sel;
		tok.number_value <= value;
		do @(posedge clk); while (tok.ready !== 1'b1);
		predict_postfix(kind, sel, value);
		gap = tx_idle_en ? pick_gap() : 0;
		if (gap != 0) begin
			tok.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tokens();
		foreach (expr_tokens[i])
			send_token(expr_tokens[i].kind, expr_tokens[i].sel, expr_tokens[i].value);
	endtask

	task automatic wait_drain();
		tok.valid <= 1'b0;
		while (postfix_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic token_t make_token(logic [KIND_W-1:0] kind);
		token_t t;
		int unsigned r;
		r = $urandom_range(0, 9);
		t.kind = kind;
		t.sel = 1'($urandom_range(0, 1));
		if (r == 0)
			t.value = {VALUE_W{1'b0}};
		else if (r == 1)
			t.value = {VALUE_W{1'b1}};
		else
			t.value = {$urandom, $urandom};
		return t;
	endfunction

	// well-formed expression with random content, closed by a token that ends it
	function automatic void build_expression(int unsigned max_depth, int unsigned lp_pct,
			int unsigned un_max);
		int unsigned depth;
		int unsigned nfac;
		int unsigned target;
		int unsigned nun;
		int unsigned r;
		bit closed;
		expr_tokens.delete();
		depth = 0;
		nfac = 0;
		closed = 1'b0;
		target = $urandom_range(1, 6);
		while (!closed) begin
			nun = ($urandom_range(0, 99) < 20) ? $urandom_range(1, un_max) : 0;
			repeat (nun) expr_tokens.push_back(make_token(K_ADD));
			while (depth < max_depth && $urandom_range(0, 99) < lp_pct) begin
				expr_tokens.push_back(make_token(K_LP));
				depth++;
			end
			expr_tokens.push_back(make_token(K_NUM));
			nfac++;
			while (depth > 0 && $urandom_range(0, 1) == 1) begin
				expr_tokens.push_back(make_token(K_RP));
				depth--;
			end
			if (nfac >= target) begin
				while (depth > 0) begin
					expr_tokens.push_back(make_token(K_RP));
					depth--;
				end
				closed = 1'b1;
			end else begin
				expr_tokens.push_back(make_token($urandom_range(0, 1) ? K_ADD : K_MUL));
			end
		end
		r = $urandom_range(0, 19);
		case (r)
			0: expr_tokens.push_back(make_token(K_NUM));
			1: expr_tokens.push_back(make_token(K_LP));
			2: expr_tokens.push_back(make_token(K_RP));
			3: expr_tokens.push_back(make_token(K_ODD6));
			4: expr_tokens.push_back(make_token(K_ODD7));
			default: expr_tokens.push_back(make_token(K_END));
		endcase
	endfunction

	task automatic test_operators();
		send_token(K_ADD, 1'b1, '0);
		send_token(K_NUM, 1'b0, {VALUE_W{1'b1}});
		send_token(K_MUL, 1'b0, '0);
		send_token(K_LP, 1'b1, {VALUE_W{1'b1}});
		send_token(K_NUM, 1'b1, {VALUE_W{1'b0}});
		send_token(K_ADD, 1'b0, {VALUE_W{1'b1}});
		send_token(K_NUM, 1'b0, 64'd5);
		send_token(K_RP, 1'b0, '0);
		send_token(K_MUL, 1'b1, '0);
		send_token(K_ADD, 1'b0, '0);
		send_token(K_NUM, 1'b1, 64'd7);
		send_token(K_ADD, 1'b1, '0);
		send_token(K_NUM, 1'b0, 64'h8000_0000_0000_0001);
		send_token(K_ODD7, 1'b1, {VALUE_W{1'b1}});
	endtask

	task automatic test_syntax_errors();
		send_token(K_RP, 1'b0, '0);
		send_token(K_LP, 1'b0, '0);
		send_token(K_NUM, 1'b0, 64'd1);
		send_token(K_NUM, 1'b0, 64'd2);
		send_token(K_ODD6, 1'b0, '0);
		send_token(K_NUM, 1'b1, 64'd9);
		send_token(K_END, 1'b0, '0);
	endtask

	task automatic test_overflow();
		repeat (11) send_token(K_LP, 1'($urandom_range(0, 1)), '0);
	endtask

	task automatic test_backpressure();
		wait_drain();
		tx_idle_en = 1'b0;
		hold_len = 400;
		-> hold_go;
		repeat (3) begin
			build_expression(4, 40, 2);
			send_tokens();
		end
		tx_idle_en = 1'b1;
		wait_drain();
	endtask

	task automatic test_random_expressions(int unsigned n_items);
		int unsigned sent;
		int unsigned shape;
		int unsigned idx;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 15) begin
				tx_idle_en = 1'b0;
				rx_idle_en <= 1'b0;
			end else begin
				tx_idle_en = 1'b1;
				rx_idle_en <= 1'b1;
			end
			shape = $urandom_range(0, 99);
			if (shape < 6) begin
				expr_tokens.delete();
				repeat ($urandom_range(1, 4))
					expr_tokens.push_back(make_token(KIND_W'($urandom_range(0, 7))));
			end else if (shape < 11) begin
				build_expression(12, 85, 2);
			end else if (shape < 14) begin
				build_expression(2, 20, 32);
			end else begin
				build_expression(3, 25, 2);
			end
			// broken sequence
			if (shape >= 6 && $urandom_range(0, 99) < 15) begin
				idx = $urandom_range(0, expr_tokens.size() - 1);
				expr_tokens[idx] = make_token(KIND_W'($urandom_range(0, 7)));
			end
			send_tokens();
			sent += expr_tokens.size();
		end
		tx_idle_en = 1'b1;
		rx_idle_en <= 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		tok.valid <= 1'b0;
		tok.token_kind <= K_NUM;
		tok.op_select <= 1'b0;
		tok.number_value <= '0;
		parser_restart();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators();
		test_syntax_errors();
		test_overflow();
		test_backpressure();
		test_random_expressions(RANDOM_ITEMS);
		wait_drain();
		if (mismatch_cnt == 0 && postfix_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
